FILE: rtl/orpe_pkg.sv
package orpe_pkg;

    localparam int TOTAL_BITS_DEFAULT = 24;
    localparam int CONTENT_W          = 24;

    localparam logic [7:0] REC_PUBDEF = 8'h90;
    localparam logic [7:0] REC_LEDATA = 8'hA0;

    typedef enum logic [12:0] {
        PH_TYPE  = 13'b0000000000001,
        PH_LLO   = 13'b0000000000010,
        PH_LHI   = 13'b0000000000100,
        PH_IDX1  = 13'b0000000001000,
        PH_IDX2  = 13'b0000000010000,
        PH_SEG1  = 13'b0000000100000,
        PH_SEG2  = 13'b0000001000000,
        PH_W1    = 13'b0000010000000,
        PH_W2    = 13'b0000100000000,
        PH_NLEN  = 13'b0001000000000,
        PH_NAME  = 13'b0010000000000,
        PH_DBODY = 13'b0100000000000,
        PH_SKIP  = 13'b1000000000000
    } phase_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_PUB   = 2'd1,
        CLS_DATA  = 2'd2
    } rec_class_t;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 byte_kind;
        logic                 name_last;
        logic                 duplicate_name;
        logic [CONTENT_W-1:0] content_total;
    } result_t;

endpackage

FILE: rtl/orpe_parser.sv
module orpe_parser #(
    parameter int TOTAL_BITS = orpe_pkg::TOTAL_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data_byte,
    output logic              res_valid,
    output orpe_pkg::result_t res
);
    import orpe_pkg::*;

    phase_t                phase_reg, phase_next;
    rec_class_t            class_reg, class_next;
    logic [15:0]           left_reg, left_next;
    logic [6:0]            idx_high_reg, idx_high_next;
    logic                  seg_zero_reg, seg_zero_next;
    logic [7:0]            name_left_reg, name_left_next;
    logic                  name_seen_reg, name_seen_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;

    logic   last;
    logic   seg_is_zero;
    phase_t body_next;
    phase_t after_index;
    phase_t after_segment;

    assign last        = (left_reg <= 16'd1);
    assign after_index = (class_reg == CLS_PUB) ? PH_SEG1 : PH_W1;
    assign seg_is_zero = (phase_reg == PH_SEG2) ? ((idx_high_reg == 7'd0) && (data_byte == 8'd0))
                                                : (data_byte == 8'd0);
    assign after_segment = seg_is_zero ? PH_W1 : PH_NLEN;

    always_comb begin
        phase_next     = phase_reg;
        class_next     = class_reg;
        left_next      = left_reg;
        idx_high_next  = idx_high_reg;
        seg_zero_next  = seg_zero_reg;
        name_left_next = name_left_reg;
        name_seen_next = name_seen_reg;
        total_next     = total_reg;
        body_next      = phase_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.out_byte   = data_byte;

        unique case (phase_reg)
            PH_TYPE: begin
                if (data_byte == REC_PUBDEF) begin
                    class_next = CLS_PUB;
                end else if (data_byte == REC_LEDATA) begin
                    class_next = CLS_DATA;
                end else begin
                    class_next = CLS_OTHER;
                end
                phase_next = PH_LLO;
            end
            PH_LLO: begin
                left_next  = {8'd0, data_byte};
                phase_next = PH_LHI;
            end
            PH_LHI: begin
                left_next = {data_byte, left_reg[7:0]};
                if ({data_byte, left_reg[7:0]} == 16'd0) begin
                    if (class_reg == CLS_PUB) begin
                        name_seen_next = 1'b1;
                    end
                    phase_next = PH_TYPE;
                end else begin
                    phase_next = (class_reg == CLS_OTHER) ? PH_SKIP : PH_IDX1;
                end
            end
            default: begin
                // Every remaining phase consumes one body byte of the record.
                unique case (phase_reg)
                    PH_IDX1:  body_next = data_byte[7] ? PH_IDX2 : after_index;
                    PH_IDX2:  body_next = after_index;
                    PH_SEG1: begin
                        if (data_byte[7]) begin
                            idx_high_next = data_byte[6:0];
                            body_next     = PH_SEG2;
                        end else begin
                            seg_zero_next = seg_is_zero;
                            body_next     = after_segment;
                        end
                    end
                    PH_SEG2: begin
                        seg_zero_next = seg_is_zero;
                        body_next     = after_segment;
                    end
                    PH_W1:    body_next = PH_W2;
                    PH_W2:    body_next = (class_reg == CLS_PUB) ? PH_NLEN : PH_DBODY;
                    PH_NLEN: begin
                        name_left_next = data_byte;
                        body_next      = (data_byte == 8'd0) ? PH_SKIP : PH_NAME;
                    end
                    PH_NAME: begin
                        res_valid          = 1'b1;
                        res.byte_kind      = 1'b0;
                        res.name_last      = (name_left_reg <= 8'd1) || last;
                        res.duplicate_name = name_seen_reg;
                        res.content_total  = CONTENT_W'(total_reg);
                        name_left_next     = name_left_reg - 8'd1;
                        if (name_left_reg == 8'd1) begin
                            body_next = PH_SKIP;
                        end
                    end
                    PH_DBODY: begin
                        // The final body byte is the checksum and is dropped.
                        if (!last) begin
                            if (total_reg != '1) begin
                                total_next = total_reg + TOTAL_BITS'(1);
                            end
                            res_valid         = 1'b1;
                            res.byte_kind     = 1'b1;
                            res.content_total = (total_reg != '1)
                                ? CONTENT_W'(total_reg + TOTAL_BITS'(1))
                                : CONTENT_W'(total_reg);
                        end
                    end
                    default:  body_next = PH_SKIP;
                endcase

                if (last) begin
                    left_next  = 16'd0;
                    phase_next = PH_TYPE;
                    if (class_reg == CLS_PUB) begin
                        name_seen_next = 1'b1;
                    end
                end else begin
                    left_next  = left_reg - 16'd1;
                    phase_next = body_next;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TYPE;
            class_reg     <= CLS_OTHER;
            left_reg      <= '0;
            idx_high_reg  <= '0;
            seg_zero_reg  <= 1'b0;
            name_left_reg <= '0;
            name_seen_reg <= 1'b0;
            total_reg     <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            class_reg     <= class_next;
            left_reg      <= left_next;
            idx_high_reg  <= idx_high_next;
            seg_zero_reg  <= seg_zero_next;
            name_left_reg <= name_left_next;
            name_seen_reg <= name_seen_next;
            total_reg     <= total_next;
        end
    end

endmodule

FILE: rtl/omf_record_payload_extractor.sv
// Splits an object-file byte stream into records and passes on the name bytes of
// public-name records and the content bytes of data records, one input word per
// cycle. A word is held in an input register, the record parser updates its state
// from it in one pass of short logic, and any result lands in an output register;
// the input register refills in the same cycle that its held word moves on, so
// throughput is one word per cycle until the output side stalls.
// The running content total saturates at 2^TOTAL_BITS - 1 and is reported in 24 bits.
module omf_record_payload_extractor #(
    parameter int TOTAL_BITS = orpe_pkg::TOTAL_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_out_byte,
    output logic                           m_byte_kind,
    output logic                           m_name_last,
    output logic                           m_duplicate_name,
    output logic [orpe_pkg::CONTENT_W-1:0] m_content_total
);
    import orpe_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic    advance;
    logic    res_valid;
    result_t res;

    // The held word moves on whenever the output register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    orpe_parser #(
        .TOTAL_BITS(TOTAL_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_out_byte       = out_reg.out_byte;
    assign m_byte_kind      = out_reg.byte_kind;
    assign m_name_last      = out_reg.name_last;
    assign m_duplicate_name = out_reg.duplicate_name;
    assign m_content_total  = out_reg.content_total;

endmodule
